@@ design/mzrt_pkg.sv @@
// shared types and constants of the multi-zone runtime timer
package mzrt_pkg;

	typedef enum logic [1:0] {
		ZM_IDLE  = 2'd0,
		ZM_RUN   = 2'd1,
		ZM_FAULT = 2'd2
	} zmode_t;

	typedef enum logic [2:0] {
		REQ_START    = 3'd0,
		REQ_STOP     = 3'd1,
		REQ_STOP_ALL = 3'd2,
		REQ_TICK     = 3'd3,
		REQ_QUERY    = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_STOP  = 2'd2,
		EV_FAULT = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_WALK = 2'd2,
		ST_EMIT = 2'd3
	} state_t;

	localparam logic [15:0] DEFAULT_RUNTIME_RST = 16'd600;

endpackage

@@ design/multi_zone_runtime_timer.sv @@
// top level of the multi-zone runtime timer: zone table, walk sequencer and output register
//
// Keeps idle/running/fault state and run counters for NUM_ZONES valve zones.
// Input channel (in_valid/in_stall) takes one request beat: req_type, zone,
// run_time, relay_good. Output channel (out_valid/out_stall) returns one or more
// result beats per request, the final one marked by last.
// Start, stop, query and unused codes: the request is executed in ST_EXEC and its
// result beat is loaded into the output register once that register is free.
// Stop-all and tick: the zone table is walked one zone per cycle through a
// single shared adder in ST_WALK, then ST_EMIT scans the stop mask one zone per
// cycle, holding on a stalled output, and reads out one beat per stopped zone,
// or a single zone-0 beat when no zone was stopped.
// in_stall stays high from the taking of a request until its final result beat
// has been loaded into the output register.
// A stalled output beat holds; the block waits for it and loses nothing.
// Reset clears all zones to idle with zero counters and sets default_runtime
// to 600; no clearing pass is needed. cfg_wr_en writes default_runtime and is to be
// used only while the block is idle; the block itself does not enforce this.
module multi_zone_runtime_timer #(
	parameter int NUM_ZONES = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [3:0]  zone,
	input  logic [15:0] run_time,
	input  logic        relay_good,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        last,
	output logic [1:0]  event_res,
	output logic [3:0]  event_zone,
	output logic        ok,
	output logic [1:0]  zone_status,
	output logic [15:0] elapsed_out,
	output logic [15:0] requested_out,
	output logic [15:0] starts_out,
	output logic [31:0] total_out,
	output logic [3:0]  active_count
);
	import mzrt_pkg::*;

	localparam int IW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(NUM_ZONES - 1);

	state_t state_q, state_d;

	logic [2:0]  op_q;
	logic [3:0]  zone_q;
	logic [15:0] rt_q;
	logic        rok_q;
	logic [15:0] dflt_q;
	logic [3:0]  act_q, act_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [NUM_ZONES-1:0] mask_q, mask_d;

	zmode_t      mode_q  [NUM_ZONES];
	logic [15:0] el_q    [NUM_ZONES];
	logic [15:0] rq_q    [NUM_ZONES];
	logic [15:0] sc_q    [NUM_ZONES];
	logic [31:0] tot_q   [NUM_ZONES];

	logic        out_valid_q;
	logic        last_q;
	logic [1:0]  event_q;
	logic [3:0]  ezone_q;
	logic        ok_q;
	logic [1:0]  status_q;
	logic [15:0] el_out_q;
	logic [15:0] rq_out_q;
	logic [15:0] sc_out_q;
	logic [31:0] tot_out_q;
	logic [3:0]  act_out_q;

	logic        ld_out;
	logic        o_last;
	event_t      o_event;
	logic [3:0]  o_zone;
	logic        o_ok;
	logic [1:0]  o_status;
	logic [15:0] o_el;
	logic [15:0] o_rq;
	logic [15:0] o_sc;
	logic [31:0] o_tot;

	logic        wr_en;
	zmode_t      wr_mode;
	logic [15:0] wr_el;
	logic [15:0] wr_rq;
	logic [15:0] wr_sc;
	logic [31:0] wr_tot;

	logic          accept;
	logic          out_free;
	logic          zvalid;
	logic [IW-1:0] zi;
	logic [IW-1:0] rd_idx;
	zmode_t        m;
	logic [15:0]   el;
	logic [15:0]   rq;
	logic [15:0]   sc;
	logic [31:0]   tot;
	logic [15:0]   el_inc;
	logic [15:0]   add_val;
	logic [31:0]   tot_sum;
	logic [NUM_ZONES-1:0] bit_sel;
	logic [NUM_ZONES-1:0] run_vec;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign zvalid = (zone_q != 4'd0) && (zone_q <= 4'(NUM_ZONES));
	assign zi     = zvalid ? IW'(zone_q - 4'd1) : '0;
	assign rd_idx = (state_q == ST_EXEC) ? zi : idx_q;

	// shared zone datapath
	assign m       = mode_q[rd_idx];
	assign el      = el_q[rd_idx];
	assign rq      = rq_q[rd_idx];
	assign sc      = sc_q[rd_idx];
	assign tot     = tot_q[rd_idx];
	assign el_inc  = (el != 16'hFFFF) ? el + 16'd1 : el;
	assign add_val = (op_q == REQ_TICK) ? el_inc : el;
	assign tot_sum = tot + 32'(add_val);
	assign bit_sel = NUM_ZONES'(1) << idx_q;

	always_comb begin
		for (int i = 0; i < NUM_ZONES; i++) begin
			run_vec[i] = (mode_q[i] == ZM_RUN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= 4'd0;
			idx_q   <= '0;
			mask_q  <= '0;
			dflt_q  <= DEFAULT_RUNTIME_RST;
		end else begin
			state_q <= state_d;
			act_q   <= act_d;
			idx_q   <= idx_d;
			mask_q  <= mask_d;
			if (cfg_wr_en) begin
				dflt_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_type;
			zone_q <= zone;
			rt_q   <= run_time;
			rok_q  <= relay_good;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ZONES; i++) begin
				mode_q[i] <= ZM_IDLE;
				el_q[i]   <= 16'd0;
				rq_q[i]   <= 16'd0;
				sc_q[i]   <= 16'd0;
				tot_q[i]  <= 32'd0;
			end
		end else if (wr_en) begin
			mode_q[rd_idx] <= wr_mode;
			el_q[rd_idx]   <= wr_el;
			rq_q[rd_idx]   <= wr_rq;
			sc_q[rd_idx]   <= wr_sc;
			tot_q[rd_idx]  <= wr_tot;
		end
	end

	always_comb begin
		state_d  = state_q;
		act_d    = act_q;
		idx_d    = idx_q;
		mask_d   = mask_q;
		wr_en    = 1'b0;
		wr_mode  = m;
		wr_el    = el;
		wr_rq    = rq;
		wr_sc    = sc;
		wr_tot   = tot;
		ld_out   = 1'b0;
		o_last   = 1'b1;
		o_event  = EV_NONE;
		o_zone   = zone_q;
		o_ok     = 1'b0;
		o_status = 2'd0;
		o_el     = 16'd0;
		o_rq     = 16'd0;
		o_sc     = 16'd0;
		o_tot    = 32'd0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d  = '0;
					mask_d = '0;
					if (req_type == REQ_STOP_ALL || req_type == REQ_TICK) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
					case (op_q)
						REQ_START: begin
							if (zvalid && m == ZM_IDLE) begin
								wr_en = 1'b1;
								if (!rok_q) begin
									wr_mode = ZM_FAULT;
									o_event = EV_FAULT;
								end else begin
									wr_mode = ZM_RUN;
									wr_el   = 16'd0;
									wr_rq   = (rt_q != 16'd0) ? rt_q : dflt_q;
									wr_sc   = sc + 16'd1;
									act_d   = act_q + 4'd1;
									o_event = EV_START;
									o_ok    = 1'b1;
								end
							end
						end
						REQ_STOP: begin
							o_ok = zvalid;
							if (zvalid && m != ZM_IDLE) begin
								wr_en   = 1'b1;
								wr_mode = ZM_IDLE;
								wr_el   = 16'd0;
								wr_tot  = tot_sum;
								o_event = EV_STOP;
								if (m == ZM_RUN) begin
									act_d = act_q - 4'd1;
								end
							end
						end
						REQ_QUERY: begin
							o_ok = zvalid;
							if (zvalid) begin
								o_status = m;
								o_el     = el;
								o_rq     = rq;
								o_sc     = sc;
								o_tot    = tot;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (op_q == REQ_TICK) begin
					if (m == ZM_RUN) begin
						wr_en = 1'b1;
						if (el_inc >= rq) begin
							wr_mode = ZM_IDLE;
							wr_el   = 16'd0;
							wr_tot  = tot_sum;
							mask_d  = mask_q | bit_sel;
							act_d   = act_q - 4'd1;
						end else begin
							wr_el = el_inc;
						end
					end
				end else if (m != ZM_IDLE) begin
					wr_en   = 1'b1;
					wr_mode = ZM_IDLE;
					wr_el   = 16'd0;
					wr_tot  = tot_sum;
					mask_d  = mask_q | bit_sel;
					if (m == ZM_RUN) begin
						act_d = act_q - 4'd1;
					end
				end
				if (idx_q == IDX_LAST) begin
					idx_d   = '0;
					state_d = ST_EMIT;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_EMIT: begin
				o_ok = 1'b1;
				if (mask_q == '0) begin
					o_zone = 4'd0;
					if (out_free) begin
						ld_out  = 1'b1;
						state_d = ST_IDLE;
					end
				end else if ((mask_q & bit_sel) != '0) begin
					o_event = EV_STOP;
					o_zone  = 4'(idx_q) + 4'd1;
					o_last  = ((mask_q & ~bit_sel) == '0);
					if (out_free) begin
						ld_out = 1'b1;
						mask_d = mask_q & ~bit_sel;
						if (o_last) begin
							idx_d   = '0;
							state_d = ST_IDLE;
						end else begin
							idx_d = idx_q + IW'(1);
						end
					end
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			last_q    <= o_last;
			event_q   <= o_event;
			ezone_q   <= o_zone;
			ok_q      <= o_ok;
			status_q  <= o_status;
			el_out_q  <= o_el;
			rq_out_q  <= o_rq;
			sc_out_q  <= o_sc;
			tot_out_q <= o_tot;
			act_out_q <= act_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign last          = last_q;
	assign event_res     = event_q;
	assign event_zone    = ezone_q;
	assign ok            = ok_q;
	assign zone_status   = status_q;
	assign elapsed_out   = el_out_q;
	assign requested_out = rq_out_q;
	assign starts_out    = sc_out_q;
	assign total_out     = tot_out_q;
	assign active_count  = act_out_q;

	a_act_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (act_q == 4'($countones(run_vec))))
		else $error("running-zone count out of step with zone table");

	a_mask_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (mask_q == '0))
		else $error("stop mask not drained before idle");

	a_mask_zones_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((mask_q & run_vec) == '0))
		else $error("stopped zone still running during readout");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q <= 4'(NUM_ZONES))
		else $error("running-zone count above zone count");

endmodule

@@ tb/tb_top.sv @@
// testbench of the multi-zone runtime timer: directed table, random requests, zone-table predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mzrt_pkg::*;

	localparam int ZONES = 15;
	localparam logic [2:0] REQ_RSVD_A = 3'd5;
	localparam logic [2:0] REQ_RSVD_B = 3'd6;
	localparam logic [2:0] REQ_RSVD_C = 3'd7;

	typedef struct {
		logic        last;
		event_t      ev;
		logic [3:0]  zn;
		logic        ok;
		zmode_t      st;
		logic [15:0] el;
		logic [15:0] rq;
		logic [15:0] sc;
		logic [31:0] tot;
		logic [3:0]  act;
	} zone_beat_t;

	typedef struct {
		logic [2:0]  rq;
		logic [3:0]  zn;
		logic [15:0] rt;
		logic        rok;
		logic        typed;
		event_t      ev;
		logic        ok;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [3:0]  zone;
	logic [15:0] run_time;
	logic        relay_good;
	logic        out_valid;
	logic        out_stall;
	logic        last;
	logic [1:0]  event_res;
	logic [3:0]  event_zone;
	logic        ok;
	logic [1:0]  zone_status;
	logic [15:0] elapsed_out;
	logic [15:0] requested_out;
	logic [15:0] starts_out;
	logic [31:0] total_out;
	logic [3:0]  active_count;

	// predicted zone table
	zmode_t      zmode [1:ZONES];
	logic [15:0] zelapsed [1:ZONES];
	logic [15:0] zrequested [1:ZONES];
	logic [15:0] zstarts [1:ZONES];
	logic [31:0] ztotal [1:ZONES];
	logic [15:0] dflt_runtime;

	zone_beat_t due_beats [$];
	int mismatches = 0;
	int n_taken = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	multi_zone_runtime_timer #(.NUM_ZONES(ZONES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .zone(zone), .run_time(run_time), .relay_good(relay_good),
		.out_valid(out_valid), .out_stall(out_stall),
		.last(last), .event_res(event_res), .event_zone(event_zone), .ok(ok),
		.zone_status(zone_status), .elapsed_out(elapsed_out), .requested_out(requested_out),
		.starts_out(starts_out), .total_out(total_out), .active_count(active_count)
	);

	dir_row_t plan [25] = '{
		'{REQ_QUERY,    4'd1,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b1},
		'{REQ_QUERY,    4'd0,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b0},
		'{REQ_STOP,     4'd3,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b1},
		'{REQ_STOP,     4'd0,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b0},
		'{REQ_STOP_ALL, 4'd0,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b1},
		'{REQ_TICK,     4'd0,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b1},
		'{REQ_START,    4'd1,  16'd0,      1'b1, 1'b1, EV_START, 1'b1},
		'{REQ_START,    4'd15, 16'hFFFF,   1'b1, 1'b1, EV_START, 1'b1},
		'{REQ_START,    4'd1,  16'd5,      1'b1, 1'b1, EV_NONE,  1'b0},
		'{REQ_START,    4'd0,  16'd5,      1'b1, 1'b1, EV_NONE,  1'b0},
		'{REQ_START,    4'd7,  16'd9,      1'b0, 1'b1, EV_FAULT, 1'b0},
		'{REQ_START,    4'd7,  16'd9,      1'b1, 1'b1, EV_NONE,  1'b0},
		'{REQ_START,    4'd2,  16'd1,      1'b1, 1'b1, EV_START, 1'b1},
		'{REQ_START,    4'd3,  16'd2,      1'b1, 1'b1, EV_START, 1'b1},
		'{REQ_TICK,     4'd0,  16'd0,      1'b0, 1'b0, EV_NONE,  1'b0},
		'{REQ_QUERY,    4'd2,  16'd0,      1'b0, 1'b0, EV_NONE,  1'b0},
		'{REQ_TICK,     4'd9,  16'd77,     1'b1, 1'b0, EV_NONE,  1'b0},
		'{REQ_QUERY,    4'd15, 16'd0,      1'b1, 1'b0, EV_NONE,  1'b0},
		'{REQ_STOP,     4'd15, 16'd0,      1'b0, 1'b1, EV_STOP,  1'b1},
		'{REQ_RSVD_A,   4'd4,  16'd0,      1'b0, 1'b1, EV_NONE,  1'b0},
		'{REQ_RSVD_B,   4'd15, 16'hFFFF,   1'b1, 1'b1, EV_NONE,  1'b0},
		'{REQ_RSVD_C,   4'd8,  16'h1234,   1'b1, 1'b1, EV_NONE,  1'b0},
		'{REQ_STOP,     4'd7,  16'd0,      1'b0, 1'b1, EV_STOP,  1'b1},
		'{REQ_STOP_ALL, 4'd0,  16'd0,      1'b0, 1'b0, EV_NONE,  1'b0},
		'{REQ_QUERY,    4'd1,  16'd0,      1'b0, 1'b0, EV_NONE,  1'b0}
	};

	function automatic zone_beat_t mk_beat(event_t ev, logic [3:0] zn, logic okv);
		zone_beat_t b;
		b.last = 1'b0;
		b.ev   = ev;
		b.zn   = zn;
		b.ok   = okv;
		b.st   = ZM_IDLE;
		b.el   = '0;
		b.rq   = '0;
		b.sc   = '0;
		b.tot  = '0;
		b.act  = '0;
		return b;
	endfunction

	function automatic void halt_zone(int i);
		ztotal[i]   = ztotal[i] + 32'(zelapsed[i]);
		zelapsed[i] = '0;
		zmode[i]    = ZM_IDLE;
	endfunction

	// updates the zone table for one request and queues the beats it should produce
	function automatic void timer_apply(logic [2:0] rq, logic [3:0] zn, logic [15:0] rt,
			logic rok, logic typed, event_t t_ev, logic t_ok);
		zone_beat_t beats [$];
		zone_beat_t b;
		logic good;
		int i;
		int nrun;
		good = (zn >= 1) && (zn <= ZONES);
		case (rq)
			REQ_START: begin
				if (!good || zmode[zn] != ZM_IDLE) begin
					beats.push_back(mk_beat(EV_NONE, zn, 1'b0));
				end else if (!rok) begin
					zmode[zn] = ZM_FAULT;
					beats.push_back(mk_beat(EV_FAULT, zn, 1'b0));
				end else begin
					zmode[zn] = ZM_RUN;
					zrequested[zn] = (rt != 0) ? rt : dflt_runtime;
					zelapsed[zn] = '0;
					zstarts[zn] = zstarts[zn] + 16'd1;
					beats.push_back(mk_beat(EV_START, zn, 1'b1));
				end
			end
			REQ_STOP: begin
				if (!good) begin
					beats.push_back(mk_beat(EV_NONE, zn, 1'b0));
				end else if (zmode[zn] == ZM_IDLE) begin
					beats.push_back(mk_beat(EV_NONE, zn, 1'b1));
				end else begin
					halt_zone(zn);
					beats.push_back(mk_beat(EV_STOP, zn, 1'b1));
				end
			end
			REQ_STOP_ALL: begin
				for (i = 1; i <= ZONES; i++) begin
					if (zmode[i] != ZM_IDLE) begin
						halt_zone(i);
						beats.push_back(mk_beat(EV_STOP, 4'(i), 1'b1));
					end
				end
				if (beats.size() == 0) beats.push_back(mk_beat(EV_NONE, 4'd0, 1'b1));
			end
			REQ_TICK: begin
				for (i = 1; i <= ZONES; i++) begin
					if (zmode[i] == ZM_RUN) begin
						if (zelapsed[i] != 16'hFFFF) zelapsed[i] = zelapsed[i] + 16'd1;
						if (zelapsed[i] >= zrequested[i]) begin
							halt_zone(i);
							beats.push_back(mk_beat(EV_STOP, 4'(i), 1'b1));
						end
					end
				end
				if (beats.size() == 0) beats.push_back(mk_beat(EV_NONE, 4'd0, 1'b1));
			end
			REQ_QUERY: begin
				b = mk_beat(EV_NONE, zn, good);
				if (good) begin
					b.st  = zmode[zn];
					b.el  = zelapsed[zn];
					b.rq  = zrequested[zn];
					b.sc  = zstarts[zn];
					b.tot = ztotal[zn];
				end
				beats.push_back(b);
			end
			default: begin
				beats.push_back(mk_beat(EV_NONE, zn, 1'b0));
			end
		endcase
		nrun = 0;
		for (i = 1; i <= ZONES; i++)
			if (zmode[i] == ZM_RUN) nrun++;
		if (typed) begin
			beats[0].ev = t_ev;
			beats[0].ok = t_ok;
		end
		beats[beats.size() - 1].last = 1'b1;
		foreach (beats[k]) begin
			beats[k].act = 4'(nrun);
			due_beats.push_back(beats[k]);
		end
	endfunction

	function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
			mismatches++;
		end
	endfunction

	task automatic send(logic [2:0] rq, logic [3:0] zn, logic [15:0] rt, logic rok,
			logic typed, event_t t_ev, logic t_ok);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		zone       <= zn;
		run_time   <= rt;
		relay_good <= rok;
		do @(posedge clk); while (in_stall);
		timer_apply(rq, zn, rt, rok, typed, t_ev, t_ok);
		n_taken++;
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [2:0]  rq;
		logic [3:0]  zn;
		logic [15:0] rt;
		logic        rok;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) rq = REQ_START;
		else if (pick < 63) rq = REQ_TICK;
		else if (pick < 73) rq = REQ_STOP;
		else if (pick < 79) rq = REQ_STOP_ALL;
		else if (pick < 95) rq = REQ_QUERY;
		else rq = 3'($urandom_range(REQ_RSVD_A, REQ_RSVD_C));
		zn = ($urandom_range(99) < 6) ? 4'd0 : 4'($urandom_range(1, ZONES));
		pick = $urandom_range(99);
		if (pick < 6) rt = '0;
		else if (pick < 16) rt = 16'($urandom);
		else rt = 16'($urandom_range(1, 6));
		rok = ($urandom_range(99) < 10) ? 1'b0 : 1'b1;
		send(rq, zn, rt, rok, 1'b0, EV_NONE, 1'b0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_beats.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_default(logic [15:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en    <= 1'b0;
		dflt_runtime = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls plus one long hold-off while requests keep coming
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && n_taken >= 40) begin
				held = 1'b1;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		zone_beat_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (due_beats.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, zone %0d event %0d",
					$time, event_zone, event_res);
				mismatches++;
			end else begin
				w = due_beats.pop_front();
				check_field("last", w.last, last);
				check_field("event_res", w.ev, event_res);
				check_field("event_zone", w.zn, event_zone);
				check_field("ok", w.ok, ok);
				check_field("zone_status", w.st, zone_status);
				check_field("elapsed_out", w.el, elapsed_out);
				check_field("requested_out", w.rq, requested_out);
				check_field("starts_out", w.sc, starts_out);
				check_field("total_out", w.tot, total_out);
				check_field("active_count", w.act, active_count);
			end
		end
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int tx_pct [4];
		int rx_pct [4];
		int count [4];
		logic [15:0] cfg_val [4];
		tx_pct = '{24, 70, 0, 0};
		rx_pct = '{70, 24, 0, 0};
		count = '{60, 60, 35, 30};
		cfg_val = '{16'd0, 16'hFFFF, 16'd3, 16'($urandom_range(1, 20))};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		req_type = REQ_START;
		zone = '0;
		run_time = '0;
		relay_good = 1'b0;
		for (int i = 1; i <= ZONES; i++) begin
			zmode[i] = ZM_IDLE;
			zelapsed[i] = '0;
			zrequested[i] = '0;
			zstarts[i] = '0;
			ztotal[i] = '0;
		end
		dflt_runtime = DEFAULT_RUNTIME_RST;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_default(16'd600);
		tx_idle_pct = tx_pct[0];
		rx_idle_pct = rx_pct[0];
		foreach (plan[r])
			send(plan[r].rq, plan[r].zn, plan[r].rt, plan[r].rok, plan[r].typed,
				plan[r].ev, plan[r].ok);
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			set_default(cfg_val[ph]);
			tx_idle_pct = tx_pct[ph];
			rx_idle_pct = rx_pct[ph];
			repeat (count[ph]) send_random();
		end
		drain();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && due_beats.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ multi_zone_runtime_timer.f @@
design/mzrt_pkg.sv
design/multi_zone_runtime_timer.sv
tb/tb_top.sv
